// ===== hdl/leb_pkg.sv =====
// Shared types, constants and codes of the line edit buffer.
`default_nettype none

package leb_pkg;

  localparam int unsigned CMD_W        = 3;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned STORE_W      = 7;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned CAPACITY_DEF = 63;

  localparam logic [CHAR_W-1:0] CHAR_LOW  = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_HIGH = 8'd126;

  typedef enum logic [CMD_W-1:0] {
    CMD_HOME  = 3'd0,
    CMD_END   = 3'd1,
    CMD_LEFT  = 3'd2,
    CMD_RIGHT = 3'd3,
    CMD_TYPE  = 3'd4,
    CMD_ERASE = 3'd5,
    CMD_PRINT = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_RESP,
    ST_PSEP,
    ST_PCHR
  } state_e;

  // One access to the text store: a registered read and a write per cycle.
  typedef struct packed {
    logic               rd_en;
    logic [LEN_W-1:0]   rd_addr;
    logic               wr_en;
    logic [LEN_W-1:0]   wr_addr;
    logic [STORE_W-1:0] wr_data;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hdl/leb_if.sv =====
// Valid/ready channel interfaces for key events and result beats.
`default_nettype none

interface leb_in_if;
  logic                        valid;
  logic                        ready;
  logic [leb_pkg::CMD_W-1:0]   cmd;
  logic [leb_pkg::CHAR_W-1:0]  char_in;
  logic [leb_pkg::CHAR_W-1:0]  separator;

  modport source (output valid, cmd, char_in, separator, input ready);
  modport sink   (input valid, cmd, char_in, separator, output ready);
endinterface

interface leb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        accepted;
  logic                        char_valid;
  logic [leb_pkg::CHAR_W-1:0]  char_out;
  logic                        last;

  modport source (output valid, accepted, char_valid, char_out, last, input ready);
  modport sink   (input valid, accepted, char_valid, char_out, last, output ready);
endinterface

`default_nettype wire

// ===== hdl/line_edit_buffer.sv =====
// Line edit buffer top level: command sequencer, text store and result register.
// Cursor moves, refused commands and an empty print without a separator show their one result
// beat from the response state. Type and erase first pass through the shift state, which
// walks the store one entry a cycle, and then show their result beat from the response state.
// Print sends one beat per cycle, separator included, while the sink keeps ready high;
// the next key event is taken in the cycle after the last beat enters the output register.
// Reset clears length, cursor, sequencer and output valid; the store itself is not cleared.
`default_nettype none

module line_edit_buffer #(
  parameter int unsigned CAPACITY = leb_pkg::CAPACITY_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  leb_in_if.sink      req_i,
  leb_out_if.source   rsp_o
);
  import leb_pkg::*;

  // Sequencer state and the registered line state.
  state_e             state_q, state_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [LEN_W-1:0]   cur_q, cur_d;
  // The walk index is shared: shift source during type and erase, text index during print.
  logic [LEN_W-1:0]   src_q, src_d;
  logic [LEN_W-1:0]   dst_q, dst_d;
  logic               pend_q, pend_d;
  logic               dir_q, dir_d;
  logic [STORE_W-1:0] char_q, char_d;
  logic [CHAR_W-1:0]  sep_q, sep_d;
  logic               acc_q, acc_d;

  // Output register that parts the sequencer from the sink.
  logic               ovld_q, ovld_d;
  logic               oacc_q, ocv_q, olast_q;
  logic [CHAR_W-1:0]  ochar_q;

  logic               slot_free;
  logic               emit;
  logic               e_acc, e_cv, e_last;
  logic [CHAR_W-1:0]  e_char;

  mem_req_t           mem_req;
  logic [STORE_W-1:0] rd_data;

  // The one shared stepper: moves the walk index up or down by one.
  logic               step_down;
  logic [LEN_W-1:0]   step;

  logic               sep_on;
  cmd_e               cmd;

  assign cmd       = cmd_e'(req_i.cmd);
  assign slot_free = !ovld_q || rsp_o.ready;
  assign step_down = (state_q == ST_SHIFT) && dir_q;
  assign step      = step_down ? (src_q - LEN_W'(1)) : (src_q + LEN_W'(1));
  assign sep_on    = (sep_q != '0);

  assign req_i.ready = (state_q == ST_IDLE);

  leb_text_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      cur_q   <= '0;
      pend_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      pend_q  <= pend_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    dst_q  <= dst_d;
    dir_q  <= dir_d;
    char_q <= char_d;
    sep_q  <= sep_d;
    acc_q  <= acc_d;
    if (emit) begin
      oacc_q  <= e_acc;
      ocv_q   <= e_cv;
      ochar_q <= e_char;
      olast_q <= e_last;
    end
  end

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    cur_d   = cur_q;
    src_d   = src_q;
    dst_d   = dst_q;
    pend_d  = pend_q;
    dir_d   = dir_q;
    char_d  = char_q;
    sep_d   = sep_q;
    acc_d   = acc_q;
    emit    = 1'b0;
    e_acc   = 1'b1;
    e_cv    = 1'b0;
    e_char  = '0;
    e_last  = 1'b1;
    mem_req = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          acc_d   = 1'b1;
          state_d = ST_RESP;
          case (cmd)
            CMD_HOME: cur_d = '0;
            CMD_END:  cur_d = len_q;
            CMD_LEFT: begin
              if (cur_q != '0) cur_d = cur_q - LEN_W'(1);
            end
            CMD_RIGHT: begin
              if (cur_q < len_q) cur_d = cur_q + LEN_W'(1);
            end
            CMD_TYPE: begin
              // Printable bytes only, and only while there is room.
              if ((req_i.char_in inside {[CHAR_LOW:CHAR_HIGH]}) &&
                  (len_q < LEN_W'(CAPACITY))) begin
                dir_d   = 1'b1;
                src_d   = len_q;
                pend_d  = 1'b0;
                char_d  = req_i.char_in[STORE_W-1:0];
                state_d = ST_SHIFT;
              end else begin
                acc_d = 1'b0;
              end
            end
            CMD_ERASE: begin
              if (cur_q != '0) begin
                dir_d   = 1'b0;
                src_d   = cur_q;
                pend_d  = 1'b0;
                state_d = ST_SHIFT;
              end else begin
                acc_d = 1'b0;
              end
            end
            CMD_PRINT: begin
              // Fetch the first character now so it is ready in the print states.
              src_d           = '0;
              sep_d           = req_i.separator;
              mem_req.rd_en   = (len_q != '0);
              mem_req.rd_addr = '0;
              if ((cur_q == '0) && (req_i.separator != '0)) begin
                state_d = ST_PSEP;
              end else if (len_q == '0) begin
                state_d = ST_RESP;
              end else begin
                state_d = ST_PCHR;
              end
            end
            default: acc_d = 1'b0;
          endcase
        end
      end

      ST_SHIFT: begin
        // The entry read in the previous cycle lands at its new place.
        mem_req.wr_en   = pend_q;
        mem_req.wr_addr = dst_q;
        mem_req.wr_data = rd_data;
        if (dir_q ? (src_q > cur_q) : (src_q < len_q)) begin
          // Insert walks down opening a gap; erase walks up closing one, so each
          // entry it reads moves one place toward the start.
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = dir_q ? step : src_q;
          dst_d           = dir_q ? src_q : (src_q - LEN_W'(1));
          src_d           = step;
          pend_d          = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            if (dir_q) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = cur_q;
              mem_req.wr_data = char_q;
              len_d           = len_q + LEN_W'(1);
              cur_d           = cur_q + LEN_W'(1);
            end else begin
              len_d = len_q - LEN_W'(1);
              cur_d = cur_q - LEN_W'(1);
            end
            acc_d   = 1'b1;
            state_d = ST_RESP;
          end
        end
      end

      ST_RESP: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_acc   = acc_q;
          state_d = ST_IDLE;
        end
      end

      ST_PSEP: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_cv   = 1'b1;
          e_char = sep_q;
          e_last = (src_q == len_q);
          if (src_q < len_q) begin
            state_d = ST_PCHR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_PCHR: begin
        if (slot_free) begin
          emit   = 1'b1;
          e_cv   = 1'b1;
          e_char = {1'b0, rd_data};
          e_last = (step == len_q) && !((cur_q == len_q) && sep_on);
          // Prefetch the next character while this one goes out.
          mem_req.rd_en   = (step < len_q);
          mem_req.rd_addr = step;
          src_d           = step;
          if ((step == cur_q) && sep_on) begin
            state_d = ST_PSEP;
          end else if (step == len_q) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_PCHR;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ovld_d = ovld_q;
    if (emit) begin
      ovld_d = 1'b1;
    end else if (rsp_o.ready) begin
      ovld_d = 1'b0;
    end
  end

  assign rsp_o.valid      = ovld_q;
  assign rsp_o.accepted   = oacc_q;
  assign rsp_o.char_valid = ocv_q;
  assign rsp_o.char_out   = ochar_q;
  assign rsp_o.last       = olast_q;

endmodule

`default_nettype wire

// ===== hdl/leb_text_store.sv =====
// Character store: one write port and one read port with registered data.
`default_nettype none

module leb_text_store #(
  parameter int unsigned DEPTH = leb_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk_i,
  input  wire leb_pkg::mem_req_t             req_i,
  output      logic [leb_pkg::STORE_W-1:0]   rd_data_o
);
  import leb_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [STORE_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr[AW-1:0]] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.rd_addr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/leb_checker.sv =====
// Port-level assertions for the line edit buffer and the bind that attaches them.
`default_nettype none

module leb_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic                        accepted_i,
  input wire logic                        char_valid_i,
  input wire logic [leb_pkg::CHAR_W-1:0]  char_out_i,
  input wire logic                        last_i
);
  import leb_pkg::*;

  // Every key event keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after a key event beat");

  // A stalled result beat holds its value.
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(char_out_i) &&
      $stable(last_i) && $stable(accepted_i) && $stable(char_valid_i)))
    else $error("stalled result beat changed");

  // Printed bytes only come from an accepted print.
  a_char_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && char_valid_i) |-> accepted_i)
    else $error("printed byte on a refused command");

  // A refused command gives one closing beat with no byte.
  a_refused_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !accepted_i) |-> (last_i && !char_valid_i))
    else $error("refused command result malformed");

  // Beats without a byte carry zero.
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !char_valid_i) |-> (char_out_i == '0))
    else $error("byte field nonzero without a printed byte");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .accepted_i   (rsp_o.accepted),
  .char_valid_i (rsp_o.char_valid),
  .char_out_i   (rsp_o.char_out),
  .last_i       (rsp_o.last)
);

`default_nettype wire
